// ===== rtl/ack_nak_retransmit_link_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ack_nak_retransmit_link_unit_macros
// Assertion shorthands shared by the link unit RTL.
// ----------------------------------------------------------------------------
`ifndef ACK_NAK_RETRANSMIT_LINK_UNIT_MACROS_SVH
`define ACK_NAK_RETRANSMIT_LINK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, idle under reset
`define ANRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication
`define ANRL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/anrl_pkg.sv =====
// ----------------------------------------------------------------------------
// anrl_pkg
// Shared constants and types of the ACK/NAK retransmit link unit.
// ----------------------------------------------------------------------------
package anrl_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagBitsDef    = 16;

  localparam int unsigned SerialW   = 32;
  localparam int unsigned FrameTagW = 16;
  localparam int unsigned ActW      = 3;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 56;

  localparam logic [CfgW-1:0] ResendIntervalRst = 16'd16;

  // received frame codes
  localparam logic [ActW-1:0] ActNone  = 3'd0;
  localparam logic [ActW-1:0] ActChat  = 3'd1;
  localparam logic [ActW-1:0] ActAck   = 3'd2;
  localparam logic [ActW-1:0] ActNak   = 3'd3;
  localparam logic [ActW-1:0] ActHshk  = 3'd4;
  localparam logic [ActW-1:0] ActCiao  = 3'd5;

  // transmitted frame codes
  localparam logic [KindW-1:0] KindChat = 2'd0;
  localparam logic [KindW-1:0] KindAck  = 2'd1;
  localparam logic [KindW-1:0] KindNak  = 2'd2;
  localparam logic [KindW-1:0] KindNone = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_TX     = 8'b0000_0010,
    S_TXRD   = 8'b0000_0100,
    S_RX     = 8'b0000_1000,
    S_POPRD  = 8'b0001_0000,
    S_POPCMP = 8'b0010_0000,
    S_OUT1   = 8'b0100_0000,
    S_OUT2   = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/anrl_ram.sv =====
// ----------------------------------------------------------------------------
// anrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module anrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ack_nak_retransmit_link_unit.sv =====
// ----------------------------------------------------------------------------
// ack_nak_retransmit_link_unit
// ACK/NAK retransmitting link: one poll word in, one or two frame words out.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one poll word per link poll; m_axis returns the frames the
//   poll causes: the sent or resent chat first, then the ACK/NAK reply, or a
//   single status word of kind none. tlast marks the final word of a poll.
//   cfg_* writes resend_interval (always ready); write it only when idle.
// Sequence
//   A poll steps through S_TX, S_TXRD for a resend of the queue head, S_RX
//   and S_OUT1, then S_OUT2 for a second word; an ACK or NAK loops through
//   S_POPRD and S_POPCMP for each queue entry examined, with a last S_POPRD
//   if the queue runs empty. One sequencer and a single serial comparator,
//   shared by the CHAT check and the retire loop, do this work in turn;
//   queue reads go through one RAM port. The next poll is accepted as soon
//   as the last word sits in the output register.
// Reset and stall
//   Reset clears serials, queue pointers, countdown and NAK flag; the queue
//   RAM needs no clearing. A stalled m_axis holds the word in the output
//   register and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`include "ack_nak_retransmit_link_unit_macros.svh"

module ack_nak_retransmit_link_unit #(
  parameter int unsigned QUEUE_DEPTH = anrl_pkg::QueueDepthDef,
  parameter int unsigned TAG_BITS    = anrl_pkg::TagBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: has_new_message[0], new_tag[16:1], rx_serial[48:17], zero pad
  input  logic [anrl_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: action[2:0]
  input  logic [anrl_pkg::ActW-1:0]     s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: frame_serial[31:0], frame_tag[47:32], deliver[48],
  //        session_end[49], push_refused[50], zero pad
  output logic [anrl_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: frame_kind[1:0]
  output logic [anrl_pkg::KindW-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [anrl_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TagW = (TAG_BITS < anrl_pkg::FrameTagW) ? TAG_BITS
                                                                  : anrl_pkg::FrameTagW;
  localparam int unsigned SerW = anrl_pkg::SerialW;
  localparam int unsigned RamW = SerW + TagW;

  anrl_pkg::state_e state_q, state_d;

  logic [anrl_pkg::CfgW-1:0] interval_q;
  logic [PtrW-1:0]           head_q, head_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [SerW-1:0]           tx_ser_q, tx_ser_d;
  logic [SerW-1:0]           rx_exp_q, rx_exp_d;
  logic [anrl_pkg::CfgW-1:0] cd_q, cd_d;
  logic                      nak_q, nak_d;

  // latched poll
  logic                      in_new_q;
  logic [TagW-1:0]           in_tag_q;
  logic [anrl_pkg::ActW-1:0] in_act_q;
  logic [SerW-1:0]           in_rx_q;

  // results of the poll in progress
  logic                       txv_q, txv_d;
  logic [SerW-1:0]            txs_q, txs_d;
  logic [TagW-1:0]            txt_q, txt_d;
  logic                       rxv_q, rxv_d;
  logic [anrl_pkg::KindW-1:0] rxk_q, rxk_d;
  logic [SerW-1:0]            rxs_q, rxs_d;
  logic                       dlv_q, dlv_d;
  logic                       end_q, end_d;
  logic                       ref_q, ref_d;

  // output register
  logic                       ov_q, ov_d;
  logic [anrl_pkg::KindW-1:0] ok_q, ok_d;
  logic [SerW-1:0]            os_q, os_d;
  logic [TagW-1:0]            ot_q, ot_d;
  logic                       od_q, od_d;
  logic                       oe_q, oe_d;
  logic                       or_q, or_d;
  logic                       ol_q, ol_d;

  logic                      accept;
  logic                      slot_free;
  logic [anrl_pkg::CfgW-1:0] reload;
  logic                      resend;
  logic                      full;
  logic                      push_en;
  logic [CntW:0]             tail_sum;
  logic [PtrW-1:0]           tail;
  logic [PtrW-1:0]           head_inc;
  logic                      ram_re;
  logic [RamW-1:0]           ram_rdata;
  logic [SerW-1:0]           ram_ser;
  logic [TagW-1:0]           ram_tag;
  logic [SerW-1:0]           cmp_a, cmp_b;
  logic                      cmp_lt, cmp_eq;
  logic                      pop;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == anrl_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign slot_free       = !ov_q || m_axis_tready_i;

  assign reload   = (interval_q == '0) ? anrl_pkg::CfgW'(1) : interval_q;
  assign resend   = nak_q || (cd_q == '0);
  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign push_en  = (state_q == anrl_pkg::S_TX) && !resend && in_new_q && !full;
  assign tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
  assign tail     = (tail_sum >= (CntW + 1)'(QUEUE_DEPTH))
                  ? PtrW'(tail_sum - (CntW + 1)'(QUEUE_DEPTH))
                  : PtrW'(tail_sum);
  assign head_inc = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  assign ram_re  = ((state_q == anrl_pkg::S_TX) && resend && (count_q != '0))
                || ((state_q == anrl_pkg::S_POPRD) && (count_q != '0));
  assign ram_ser = ram_rdata[SerW-1:0];
  assign ram_tag = ram_rdata[RamW-1:SerW];

  anrl_ram #(
    .WIDTH (RamW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (tail),
    .wdata_i ({in_tag_q, tx_ser_q}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // shared serial comparator
  assign cmp_a  = (state_q == anrl_pkg::S_POPCMP) ? ram_ser : in_rx_q;
  assign cmp_b  = (state_q == anrl_pkg::S_POPCMP) ? in_rx_q : rx_exp_q;
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;
  assign pop    = (in_act_q == anrl_pkg::ActAck) ? (cmp_lt || cmp_eq) : cmp_lt;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    tx_ser_d = tx_ser_q;
    rx_exp_d = rx_exp_q;
    cd_d     = cd_q;
    nak_d    = nak_q;
    txv_d    = txv_q;
    txs_d    = txs_q;
    txt_d    = txt_q;
    rxv_d    = rxv_q;
    rxk_d    = rxk_q;
    rxs_d    = rxs_q;
    dlv_d    = dlv_q;
    end_d    = end_q;
    ref_d    = ref_q;
    ov_d     = ov_q && !m_axis_tready_i;
    ok_d     = ok_q;
    os_d     = os_q;
    ot_d     = ot_q;
    od_d     = od_q;
    oe_d     = oe_q;
    or_d     = or_q;
    ol_d     = ol_q;

    case (state_q)
      anrl_pkg::S_IDLE: begin
        if (accept) begin
          txv_d   = 1'b0;
          rxv_d   = 1'b0;
          dlv_d   = 1'b0;
          end_d   = 1'b0;
          ref_d   = 1'b0;
          state_d = anrl_pkg::S_TX;
        end
      end
      anrl_pkg::S_TX: begin
        state_d = anrl_pkg::S_RX;
        if (resend) begin
          nak_d = 1'b0;
          cd_d  = reload - 1'b1;
          if (count_q != '0) begin
            state_d = anrl_pkg::S_TXRD;
          end
        end else begin
          cd_d = cd_q - 1'b1;
          if (in_new_q) begin
            if (full) begin
              ref_d = 1'b1;
            end else begin
              txv_d    = 1'b1;
              txs_d    = tx_ser_q;
              txt_d    = in_tag_q;
              count_d  = count_q + 1'b1;
              tx_ser_d = tx_ser_q + 1'b1;
            end
          end
        end
      end
      anrl_pkg::S_TXRD: begin
        txv_d   = 1'b1;
        txs_d   = ram_ser;
        txt_d   = ram_tag;
        state_d = anrl_pkg::S_RX;
      end
      anrl_pkg::S_RX: begin
        state_d = anrl_pkg::S_OUT1;
        case (in_act_q)
          anrl_pkg::ActChat: begin
            rxv_d = 1'b1;
            cd_d  = reload;
            if (cmp_lt) begin
              rxk_d = anrl_pkg::KindAck;
              rxs_d = rx_exp_q - 1'b1;
            end else if (cmp_eq) begin
              rxk_d    = anrl_pkg::KindAck;
              rxs_d    = rx_exp_q;
              dlv_d    = 1'b1;
              rx_exp_d = rx_exp_q + 1'b1;
            end else begin
              rxk_d = anrl_pkg::KindNak;
              rxs_d = rx_exp_q;
            end
          end
          anrl_pkg::ActAck: begin
            state_d = anrl_pkg::S_POPRD;
          end
          anrl_pkg::ActNak: begin
            nak_d   = 1'b1;
            state_d = anrl_pkg::S_POPRD;
          end
          anrl_pkg::ActHshk, anrl_pkg::ActCiao: begin
            head_d   = '0;
            count_d  = '0;
            tx_ser_d = '0;
            rx_exp_d = '0;
            cd_d     = '0;
            nak_d    = 1'b0;
            end_d    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      anrl_pkg::S_POPRD: begin
        state_d = (count_q == '0) ? anrl_pkg::S_OUT1 : anrl_pkg::S_POPCMP;
      end
      anrl_pkg::S_POPCMP: begin
        if (pop) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          state_d = anrl_pkg::S_POPRD;
        end else begin
          state_d = anrl_pkg::S_OUT1;
        end
      end
      anrl_pkg::S_OUT1: begin
        if (slot_free) begin
          ov_d = 1'b1;
          if (txv_q) begin
            ok_d = anrl_pkg::KindChat;
            os_d = txs_q;
            ot_d = txt_q;
            ol_d = !rxv_q;
          end else if (rxv_q) begin
            ok_d = rxk_q;
            os_d = rxs_q;
            ot_d = '0;
            ol_d = 1'b1;
          end else begin
            ok_d = anrl_pkg::KindNone;
            os_d = '0;
            ot_d = '0;
            ol_d = 1'b1;
          end
          od_d    = dlv_q && !(txv_q && rxv_q);
          oe_d    = end_q && !(txv_q && rxv_q);
          or_d    = ref_q && !(txv_q && rxv_q);
          state_d = (txv_q && rxv_q) ? anrl_pkg::S_OUT2 : anrl_pkg::S_IDLE;
        end
      end
      anrl_pkg::S_OUT2: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ok_d    = rxk_q;
          os_d    = rxs_q;
          ot_d    = '0;
          ol_d    = 1'b1;
          od_d    = dlv_q;
          oe_d    = end_q;
          or_d    = ref_q;
          state_d = anrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = anrl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= anrl_pkg::S_IDLE;
      interval_q <= anrl_pkg::ResendIntervalRst;
      head_q     <= '0;
      count_q    <= '0;
      tx_ser_q   <= '0;
      rx_exp_q   <= '0;
      cd_q       <= '0;
      nak_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      tx_ser_q <= tx_ser_d;
      rx_exp_q <= rx_exp_d;
      cd_q     <= cd_d;
      nak_q    <= nak_d;
      ov_q     <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        interval_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_new_q <= s_axis_tdata_i[0];
      in_tag_q <= s_axis_tdata_i[TagW:1];
      in_act_q <= s_axis_tuser_i;
      in_rx_q  <= s_axis_tdata_i[48:17];
    end
    txv_q <= txv_d;
    txs_q <= txs_d;
    txt_q <= txt_d;
    rxv_q <= rxv_d;
    rxk_q <= rxk_d;
    rxs_q <= rxs_d;
    dlv_q <= dlv_d;
    end_q <= end_d;
    ref_q <= ref_d;
    ok_q  <= ok_d;
    os_q  <= os_d;
    ot_q  <= ot_d;
    od_q  <= od_d;
    oe_q  <= oe_d;
    or_q  <= or_d;
    ol_q  <= ol_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = ok_q;
  assign m_axis_tlast_o  = ol_q;
  assign m_axis_tdata_o  = {5'd0, or_q, oe_q, od_q,
                            anrl_pkg::FrameTagW'(ot_q), os_q};

  `ANRL_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "queue count beyond depth")
  `ANRL_ASSERT(a_popcmp_nonempty, (state_q != anrl_pkg::S_POPCMP) || (count_q != '0),
               "retire compare on empty queue")
  `ANRL_ASSERT(a_out2_pending, (state_q != anrl_pkg::S_OUT2) || (ov_q && !ol_q),
               "second word pending without a held first word")
  `ANRL_ASSERT_NEXT(a_push_count, push_en, count_q == $past(count_q) + 1'b1,
                    "push did not grow the queue")

endmodule

// ===== tb/sv/ack_nak_retransmit_link_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_nak_retransmit_link_unit_tb
// Drives link polls into the unit under random burst and stall patterns,
// predicts the frame words each poll causes from a software copy of the
// queue, serials, countdown and NAK flag, and checks every output word field
// by field. Runs a directed opening and a queue fill, then random phases at
// several resend intervals, the extremes among them.
// ----------------------------------------------------------------------------
module ack_nak_retransmit_link_unit_tb;
  import anrl_pkg::*;

  localparam int unsigned QDEPTH       = QueueDepthDef;
  localparam int unsigned WATCHDOG_MAX = 3000;
  localparam int unsigned SETTLE_CYC   = 60;
  localparam int unsigned PHASE_POLLS  = 75;
  localparam logic [ActW-1:0] ActRsvd6 = 3'd6;
  localparam logic [ActW-1:0] ActRsvd7 = 3'd7;

  typedef struct {
    logic [KindW-1:0]     kind;
    logic [SerialW-1:0]   serial;
    logic [FrameTagW-1:0] tag;
    logic                 deliver;
    logic                 ended;
    logic                 refused;
    logic                 last;
  } frame_t;

  class link_scoreboard;
    logic [SerialW-1:0]   q_serial [QDEPTH];
    logic [FrameTagW-1:0] q_tag [QDEPTH];
    int unsigned          head;
    int unsigned          count;
    logic [SerialW-1:0]   tx_serial;
    logic [SerialW-1:0]   rx_expect;
    logic [CfgW-1:0]      countdown;
    logic                 nak_flag;
    logic [CfgW-1:0]      interval;
    frame_t               expected_frames [$];
    int unsigned          fails;

    function new();
      clear_session();
      interval = ResendIntervalRst;
      fails    = 0;
    endfunction

    function void clear_session();
      head      = 0;
      count     = 0;
      tx_serial = '0;
      rx_expect = '0;
      countdown = '0;
      nak_flag  = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    function void retire(logic [SerialW-1:0] limit, bit inclusive);
      logic [SerialW-1:0] s;
      while (count > 0) begin
        s = q_serial[head];
        if (inclusive ? (s > limit) : (s >= limit)) break;
        head  = (head + 1) % QDEPTH;
        count = count - 1;
      end
    endfunction

    function frame_t frame(logic [KindW-1:0] kind, logic [SerialW-1:0] serial,
                           logic [FrameTagW-1:0] tag);
      frame_t f;
      f.kind    = kind;
      f.serial  = serial;
      f.tag     = tag;
      f.deliver = 1'b0;
      f.ended   = 1'b0;
      f.refused = 1'b0;
      f.last    = 1'b0;
      return f;
    endfunction

    function void note_poll(logic has_new, logic [FrameTagW-1:0] tag,
                            logic [ActW-1:0] act, logic [SerialW-1:0] rxs);
      frame_t          words [$];
      frame_t          w;
      logic [CfgW-1:0] reload;
      int unsigned     slot;
      logic            deliver;
      logic            ended;
      logic            refused;
      deliver = 1'b0;
      ended   = 1'b0;
      refused = 1'b0;
      reload  = (interval == '0) ? 16'd1 : interval;
      // transmit side
      if (nak_flag || countdown == '0) begin
        if (count > 0) words.push_back(frame(KindChat, q_serial[head], q_tag[head]));
        nak_flag  = 1'b0;
        countdown = reload;
      end else if (has_new) begin
        if (count >= QDEPTH) begin
          refused = 1'b1;
        end else begin
          slot           = (head + count) % QDEPTH;
          q_serial[slot] = tx_serial;
          q_tag[slot]    = tag;
          count          = count + 1;
          words.push_back(frame(KindChat, tx_serial, tag));
          tx_serial      = tx_serial + 1;
        end
      end
      countdown = countdown - 1'b1;
      // receive side
      case (act)
        ActChat: begin
          if (rxs > rx_expect) begin
            words.push_back(frame(KindNak, rx_expect, '0));
          end else if (rxs < rx_expect) begin
            words.push_back(frame(KindAck, rx_expect - 1, '0));
          end else begin
            words.push_back(frame(KindAck, rx_expect, '0));
            deliver   = 1'b1;
            rx_expect = rx_expect + 1;
          end
          countdown = reload;
        end
        ActAck: retire(rxs, 1'b1);
        ActNak: begin
          retire(rxs, 1'b0);
          nak_flag = 1'b1;
        end
        ActHshk, ActCiao: begin
          clear_session();
          ended = 1'b1;
        end
        default: ;
      endcase
      if (words.size() == 0) words.push_back(frame(KindNone, '0, '0));
      w         = words.pop_back();
      w.deliver = deliver;
      w.ended   = ended;
      w.refused = refused;
      w.last    = 1'b1;
      words.push_back(w);
      foreach (words[i]) expected_frames.push_back(words[i]);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        fails = fails + 1;
      end
    endfunction

    function void check_frame(logic [KindW-1:0] kind, logic [OutDataW-1:0] data,
                              logic last);
      frame_t e;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d data %h last %b",
                 $time, kind, data, last);
        fails = fails + 1;
        return;
      end
      e = expected_frames.pop_front();
      compare("frame_kind", 64'(e.kind), 64'(kind));
      compare("frame_serial", 64'(e.serial), 64'(data[31:0]));
      compare("frame_tag", 64'(e.tag), 64'(data[47:32]));
      compare("deliver", 64'(e.deliver), 64'(data[48]));
      compare("session_end", 64'(e.ended), 64'(data[49]));
      compare("push_refused", 64'(e.refused), 64'(data[50]));
      compare("last", 64'(e.last), 64'(last));
    endfunction
  endclass

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic [InDataW-1:0]    s_tdata   = '0;
  logic [ActW-1:0]       s_tuser   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_axis_tready_o;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic [KindW-1:0]      m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tvalid_o;
  logic                  m_tready  = 1'b0;
  logic [CfgW-1:0]       cfg_data  = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;

  link_scoreboard        sb;
  int unsigned           burst_left  = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           rx_cyc      = 0;
  int unsigned           rx_mode     = 0;

  ack_nak_retransmit_link_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_data_i      (cfg_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stall pattern, in one of four modes re-drawn at random
  always @(negedge clk_i) begin
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
    rx_cyc = rx_cyc + 1;
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rx_cyc % 11) >= 8;
      default: m_tready <= $urandom_range(0, 9) < 8;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_frame(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
          $display("%0t: timeout, %0d words outstanding", $time, sb.pending());
          $display("ack_nak_retransmit_link_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic write_interval(logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.interval = value;
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  task automatic send_poll(logic has_new, logic [FrameTagW-1:0] tag,
                           logic [ActW-1:0] act, logic [SerialW-1:0] rxs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      @(negedge clk_i) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left = burst_left - 1;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, rxs, tag, has_new};
    s_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_poll(has_new, tag, act, rxs);
  endtask

  // hold off the sender until every expected word is out, then let it settle
  task automatic drain();
    @(negedge clk_i) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [SerialW-1:0] pick_queued();
    return sb.q_serial[(sb.head + $urandom_range(0, sb.count - 1)) % QDEPTH];
  endfunction

  task automatic random_poll();
    logic                 has_new;
    logic [FrameTagW-1:0] tag;
    logic [ActW-1:0]      act;
    logic [SerialW-1:0]   rxs;
    int unsigned          r;
    int unsigned          sel;
    has_new = $urandom_range(0, 99) < 70;
    tag     = FrameTagW'($urandom);
    r       = $urandom_range(0, 99);
    sel     = $urandom_range(0, 99);
    rxs     = $urandom;
    if (r < 35) begin
      act = ActNone;
    end else if (r < 60) begin
      act = ActChat;
      if (sel < 50)      rxs = sb.rx_expect;
      else if (sel < 65) rxs = sb.rx_expect - 1;
      else if (sel < 80) rxs = sb.rx_expect + 1;
    end else if (r < 78) begin
      act = ActAck;
      if (sb.count > 0 && sel < 70) rxs = pick_queued();
      else if (sel < 85)            rxs = sb.tx_serial - 1;
    end else if (r < 91) begin
      act = ActNak;
      if (sb.count > 0 && sel < 75) rxs = pick_queued();
      else if (sel < 90)            rxs = sb.tx_serial;
    end else if (r < 94) begin
      act = ActHshk;
    end else if (r < 97) begin
      act = ActCiao;
    end else begin
      act = (r < 99) ? ActRsvd6 : ActRsvd7;
    end
    send_poll(has_new, tag, act, rxs);
  endtask

  initial begin
    logic [CfgW-1:0] intervals [7];
    sb = new();
    intervals = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd5, 16'd3, ResendIntervalRst};
    intervals[5] = CfgW'($urandom_range(3, 64));
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    write_interval(ResendIntervalRst);
    send_poll(1'b0, 16'h0000, ActNone, 32'h0);            // resend with empty queue
    send_poll(1'b1, 16'hFFFF, ActNone, 32'hFFFF_FFFF);
    send_poll(1'b1, 16'h0000, ActChat, 32'h0);            // in-order chat
    send_poll(1'b1, 16'hA5A5, ActChat, 32'h0);            // stale chat
    send_poll(1'b0, 16'h5A5A, ActChat, 32'hFFFF_FFFF);    // chat ahead, NAK
    send_poll(1'b0, 16'h0000, ActAck, 32'h0);
    send_poll(1'b1, 16'h1234, ActNak, 32'h2);
    send_poll(1'b1, 16'h4321, ActNone, 32'h0);            // resend after NAK
    send_poll(1'b1, 16'h00FF, ActRsvd6, 32'h8000_0000);
    send_poll(1'b1, 16'hFF00, ActRsvd7, 32'h7FFF_FFFF);
    send_poll(1'b0, 16'h0000, ActHshk, 32'h0);
    send_poll(1'b1, 16'h0F0F, ActChat, 32'h0);
    send_poll(1'b1, 16'hF0F0, ActCiao, 32'h5);
    drain();

    // fill the queue past its depth, then retire it
    write_interval(16'hFFFF);
    send_poll(1'b0, 16'h0000, ActNone, 32'h0);
    for (int i = 0; i <= QDEPTH; i++) begin
      send_poll(1'b1, FrameTagW'($urandom), ActNone, $urandom);
    end
    send_poll(1'b1, 16'hBEEF, ActNak, 32'h5);
    send_poll(1'b0, 16'h0000, ActNone, 32'h0);
    send_poll(1'b1, 16'hCAFE, ActAck, 32'hFFFF_FFFF);
    drain();

    foreach (intervals[p]) begin
      write_interval(intervals[p]);
      repeat (PHASE_POLLS) random_poll();
      drain();
    end

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("ack_nak_retransmit_link_unit_tb OK");
    end else begin
      $display("ack_nak_retransmit_link_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/anrl_pkg.sv
rtl/anrl_ram.sv
rtl/ack_nak_retransmit_link_unit.sv
tb/sv/ack_nak_retransmit_link_unit_tb.sv
